[rtl/core/cfdp_pkg.sv]
package cfdp_pkg;

    // field widths
    localparam int SAMPLE_BITS    = 12;
    localparam int FRACTION_BITS  = 8;
    localparam int TIME_BITS      = 15;
    localparam int TBASE_BITS     = TIME_BITS - FRACTION_BITS;
    localparam int DELAY_BITS     = 4;
    localparam int GAIN_BITS      = 8;
    localparam int GAIN_FRAC_BITS = 4;
    localparam int THRESH_BITS    = 16;
    localparam int DIFF_BITS      = 22;
    localparam int DEN_BITS       = DIFF_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // delay line and queue sizes
    localparam int MAX_DELAY   = 15;
    localparam int QUEUE_DEPTH = 4;

    // trace index landmarks
    localparam int BASE_EVEN_INDEX = 2;
    localparam int BASE_ODD_INDEX  = 3;
    localparam int TIME_OFFSET     = 5;

    // register reset values
    localparam logic [DELAY_BITS-1:0]  DELAY_RESET  = 4'd2;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 8'd32;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd20;

    // register indexes
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_DELAY     = 2'd0;
    localparam cfg_index_t CFG_GAIN      = 2'd1;
    localparam cfg_index_t CFG_THRESHOLD = 2'd2;

    // one job handed from the front end to the back end
    typedef struct packed {
        logic                  crossing;
        logic [TBASE_BITS-1:0] time_base;
        logic [DIFF_BITS-1:0]  prev;
        logic [DEN_BITS-1:0]   den;
        logic                  trace_end;
        logic                  had_hit;
    } job_t;

endpackage

[rtl/core/cfdp_in_if.sv]
interface cfdp_in_if;

    logic                             valid;
    logic                             ready;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] sample;
    logic                             last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);

endinterface

[rtl/core/cfdp_out_if.sv]
interface cfdp_out_if;

    logic                                  valid;
    logic                                  ready;
    logic                                  crossing_valid;
    logic signed [cfdp_pkg::TIME_BITS-1:0] crossing_time;
    logic                                  trace_end;
    logic                                  trace_had_hit;

    modport source (
        output valid, output crossing_valid, output crossing_time,
        output trace_end, output trace_had_hit, input ready
    );
    modport sink (
        input valid, input crossing_valid, input crossing_time,
        input trace_end, input trace_had_hit, output ready
    );

endinterface

[rtl/core/cfdp_cfg_if.sv]
interface cfdp_cfg_if;

    logic                               valid;
    logic                               ready;
    logic [cfdp_pkg::CFG_INDEX_BITS-1:0] index;
    logic [cfdp_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

[rtl/core/digital_cfd_time_pickoff_top.sv]
// Digital constant fraction time pickoff. Samples of one ADC trace enter on
// sample_ch, one item per clock while the four-entry job queue has room; the
// front end updates the trace state (baselines, delay line, difference) in
// the cycle the item is taken. A sample that ends in a qualifying falling
// crossing or marks trace end becomes a job for the back end, which gives one
// item on result_ch; for a crossing the one-bit-per-cycle restoring divider
// first works out the interpolation fraction, and each item is held until
// result_ch.ready. Register writes on cfg_ch (0 delay, 1 gain Q4.4, 2
// threshold) are taken at any time and belong between traces; MAX_SAMPLES
// bounds the trace length, later samples are dropped except for their trace
// end mark.
module digital_cfd_time_pickoff_top #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    cfdp_in_if.sink     sample_ch,
    cfdp_cfg_if.sink    cfg_ch,
    cfdp_out_if.source  result_ch
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    cfdp_pkg::job_t push_job;
    cfdp_pkg::job_t head_job;

    // sample intake and crossing detection
    cfdp_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .cfg_ch     (cfg_ch),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // job queue between front and back end
    cfdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // fraction division and result output
    cfdp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head_job),
        .pop         (pop),
        .result_ch   (result_ch)
    );

endmodule

[rtl/core/cfdp_front.sv]
module cfdp_front #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    cfdp_in_if.sink         sample_ch,
    cfdp_cfg_if.sink        cfg_ch,
    input  logic            queue_full,
    output logic            push,
    output cfdp_pkg::job_t  job
);

    localparam int IDX_BITS  = $clog2(MAX_SAMPLES + 1);
    localparam int EXT_BITS  = (IDX_BITS > cfdp_pkg::TBASE_BITS) ? IDX_BITS
                                                                  : cfdp_pkg::TBASE_BITS;
    localparam int DSEL_BITS = $clog2(cfdp_pkg::MAX_DELAY);
    localparam int ORIG_BITS = cfdp_pkg::SAMPLE_BITS + 1;
    localparam int DB        = cfdp_pkg::DIFF_BITS;

    // configuration registers
    logic [cfdp_pkg::DELAY_BITS-1:0]  delay_reg;
    logic [cfdp_pkg::GAIN_BITS-1:0]   gain_reg;
    logic [cfdp_pkg::THRESH_BITS-1:0] thresh_reg;

    // per trace state
    logic [IDX_BITS-1:0]              idx_reg, idx_next;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] base_even_reg, base_even_next;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] base_odd_reg, base_odd_next;
    logic signed [DB-1:0]             prev_reg, prev_next;
    logic                             hit_reg, hit_next;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] dline_reg [cfdp_pkg::MAX_DELAY];

    // datapath
    logic                             accept;
    logic                             active;
    logic                             window;
    logic                             hit;
    logic [cfdp_pkg::DELAY_BITS-1:0]  dsel;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] delayed;
    logic [cfdp_pkg::SAMPLE_BITS-1:0] b_even, b_odd, base;
    logic signed [ORIG_BITS-1:0]      orig, dly;
    logic signed [DB-1:0]             prod, diff;
    logic [cfdp_pkg::DEN_BITS-1:0]    den, thr_scaled;
    logic [EXT_BITS-1:0]              tbase_ext;

    assign sample_ch.ready = !queue_full;
    assign cfg_ch.ready    = 1'b1;
    assign accept          = sample_ch.valid && !queue_full;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= cfdp_pkg::DELAY_RESET;
            gain_reg   <= cfdp_pkg::GAIN_RESET;
            thresh_reg <= cfdp_pkg::THRESH_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                cfdp_pkg::CFG_DELAY:
                    delay_reg <= cfg_ch.data[cfdp_pkg::DELAY_BITS-1:0];
                cfdp_pkg::CFG_GAIN:
                    gain_reg <= cfg_ch.data[cfdp_pkg::GAIN_BITS-1:0];
                cfdp_pkg::CFG_THRESHOLD:
                    thresh_reg <= cfg_ch.data[cfdp_pkg::THRESH_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // delayed copy and baseline selection
    always_comb
    begin
        active = idx_reg < IDX_BITS'(MAX_SAMPLES);
        dsel   = (delay_reg > cfdp_pkg::DELAY_BITS'(cfdp_pkg::MAX_DELAY))
               ? cfdp_pkg::DELAY_BITS'(cfdp_pkg::MAX_DELAY) : delay_reg;
        if (dsel == '0)
            delayed = sample_ch.sample;
        else
            delayed = dline_reg[DSEL_BITS'(dsel - 1'b1)];
        b_even = (idx_reg == IDX_BITS'(cfdp_pkg::BASE_EVEN_INDEX))
               ? sample_ch.sample : base_even_reg;
        b_odd  = (idx_reg == IDX_BITS'(cfdp_pkg::BASE_ODD_INDEX))
               ? sample_ch.sample : base_odd_reg;
        base   = idx_reg[0] ? b_odd : b_even;
    end

    // difference of original and amplified delayed copy, in 1/16 adc units
    always_comb
    begin
        orig = $signed({1'b0, sample_ch.sample}) - $signed({1'b0, base});
        dly  = $signed({1'b0, delayed}) - $signed({1'b0, base});
        prod = DB'(dly) * DB'($signed({1'b0, gain_reg}));
        diff = (DB'(orig) <<< cfdp_pkg::GAIN_FRAC_BITS) - prod;
    end

    // falling zero crossing test
    always_comb
    begin
        window     = active && ({1'b0, idx_reg} >=
                     ((IDX_BITS + 1)'(dsel) + (IDX_BITS + 1)'(cfdp_pkg::BASE_EVEN_INDEX)));
        den        = {prev_reg[DB-1], prev_reg} - {diff[DB-1], diff};
        thr_scaled = cfdp_pkg::DEN_BITS'({thresh_reg, {cfdp_pkg::GAIN_FRAC_BITS{1'b0}}});
        hit        = window && (idx_reg > IDX_BITS'(cfdp_pkg::BASE_ODD_INDEX))
                     && diff[DB-1] && !prev_reg[DB-1] && (den > thr_scaled);
        tbase_ext  = EXT_BITS'(idx_reg) - EXT_BITS'(cfdp_pkg::TIME_OFFSET);
    end

    // next trace state
    always_comb
    begin
        idx_next       = idx_reg;
        base_even_next = base_even_reg;
        base_odd_next  = base_odd_reg;
        prev_next      = prev_reg;
        hit_next       = hit_reg;
        if (accept)
        begin
            if (active)
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_BITS'(cfdp_pkg::BASE_EVEN_INDEX))
                    base_even_next = sample_ch.sample;
                if (idx_reg == IDX_BITS'(cfdp_pkg::BASE_ODD_INDEX))
                    base_odd_next = sample_ch.sample;
                if (window)
                    prev_next = diff;
                if (hit)
                    hit_next = 1'b1;
            end
            if (sample_ch.last_sample)
            begin
                idx_next       = '0;
                base_even_next = '0;
                base_odd_next  = '0;
                prev_next      = '0;
                hit_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            base_even_reg <= '0;
            base_odd_reg  <= '0;
            prev_reg      <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            base_even_reg <= base_even_next;
            base_odd_reg  <= base_odd_next;
            prev_reg      <= prev_next;
            hit_reg       <= hit_next;
        end
    end

    // sample shift line, newest in slot 0
    always_ff @(posedge clk)
    begin
        if (accept && active)
        begin
            dline_reg[0] <= sample_ch.sample;
            for (int k = 1; k < cfdp_pkg::MAX_DELAY; k++)
            begin
                dline_reg[k] <= dline_reg[k-1];
            end
        end
    end

    // hand a job to the back end for every item that gives a result
    always_comb
    begin
        push          = accept && (hit || sample_ch.last_sample);
        job.crossing  = hit;
        job.time_base = tbase_ext[cfdp_pkg::TBASE_BITS-1:0];
        job.prev      = prev_reg;
        job.den       = den;
        job.trace_end = sample_ch.last_sample;
        job.had_hit   = sample_ch.last_sample && (hit_reg || hit);
    end

endmodule

[rtl/core/cfdp_queue.sv]
module cfdp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfdp_pkg::job_t  push_job,
    input  logic            pop,
    output cfdp_pkg::job_t  head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_BITS = $clog2(cfdp_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(cfdp_pkg::QUEUE_DEPTH + 1);

    cfdp_pkg::job_t      slot_reg [cfdp_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_BITS'(cfdp_pkg::QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_next  = push ? PTR_BITS'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? PTR_BITS'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

[rtl/core/cfdp_back.sv]
module cfdp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  cfdp_pkg::job_t  head,
    output logic            pop,
    cfdp_out_if.source      result_ch
);

    localparam int FB       = cfdp_pkg::FRACTION_BITS;
    localparam int NB       = cfdp_pkg::DEN_BITS;
    localparam int CNT_BITS = $clog2(FB);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    state_t                          state_reg, state_next;
    logic [NB-1:0]                   rem_reg, rem_next;
    logic [NB-1:0]                   den_reg, den_next;
    logic [FB-1:0]                   quo_reg, quo_next;
    logic [CNT_BITS-1:0]             cnt_reg, cnt_next;
    logic [cfdp_pkg::TBASE_BITS-1:0] tbase_reg, tbase_next;
    logic                            cross_reg, cross_next;
    logic                            end_reg, end_next;
    logic                            had_reg, had_next;

    // sequencer and restoring divider, one quotient bit per cycle
    always_comb
    begin
        logic [NB:0] r2;
        logic        qbit;
        r2         = {rem_reg, 1'b0};
        qbit       = r2 >= {1'b0, den_reg};
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        tbase_next = tbase_reg;
        cross_next = cross_reg;
        end_next   = end_reg;
        had_next   = had_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    rem_next   = NB'(head.prev);
                    den_next   = head.den;
                    quo_next   = '0;
                    cnt_next   = '0;
                    tbase_next = head.crossing ? head.time_base : '0;
                    cross_next = head.crossing;
                    end_next   = head.trace_end;
                    had_next   = head.had_hit;
                    state_next = head.crossing ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (qbit)
                    rem_next = NB'(r2 - {1'b0, den_reg});
                else
                    rem_next = NB'(r2);
                quo_next = {quo_reg[FB-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(FB - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result_ch.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            tbase_reg <= '0;
            cross_reg <= 1'b0;
            end_reg   <= 1'b0;
            had_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
            tbase_reg <= tbase_next;
            cross_reg <= cross_next;
            end_reg   <= end_next;
            had_reg   <= had_next;
        end
    end

    // result item
    assign result_ch.valid          = state_reg == ST_OUT;
    assign result_ch.crossing_valid = cross_reg;
    assign result_ch.crossing_time  = $signed({tbase_reg, quo_reg});
    assign result_ch.trace_end      = end_reg;
    assign result_ch.trace_had_hit  = had_reg;

endmodule
